[src/lpsd_pkg.sv]
// Package for the length-prefixed string deframer.
// Holds register indexes, field widths and the UTF-8 encoding constants.
// No dependencies.
package lpsd_pkg;

  localparam int unsigned STRINGS_PER_BLOCK = 16;
  localparam int unsigned IDX_W    = 5;
  localparam int unsigned OFFSET_W = 21;
  localparam int unsigned ID_W     = 16;

  // configuration register indexes
  localparam logic [1:0] REG_SOURCE_FORMAT = 2'd0;
  localparam logic [1:0] REG_BLOCK_NUMBER  = 2'd1;
  localparam logic [1:0] REG_TOTAL_BYTES   = 2'd2;

  // source formats
  localparam logic FMT_WIDE   = 1'b0;
  localparam logic FMT_NARROW = 1'b1;

  // UTF-8 encoding
  localparam logic [15:0] UTF8_ONE_LIMIT = 16'h0080;
  localparam logic [15:0] UTF8_TWO_LIMIT = 16'h0800;
  localparam logic [7:0]  UTF8_LEAD2     = 8'hC0;
  localparam logic [7:0]  UTF8_LEAD3     = 8'hE0;
  localparam logic [7:0]  UTF8_CONT      = 8'h80;
  localparam logic [5:0]  UTF8_CONT_MASK = 6'h3F;

endpackage

[src/length_prefixed_string_deframer_top.sv]
// Top level of the length-prefixed string deframer.
// Depends on lpsd_pkg.
//
// The block takes a string-table block one byte per beat and emits the bytes of up to sixteen
// length-prefixed strings, each tagged with its string id ((block_number-1)*16 + index, mod
// 65536). In wide mode (source_format 0) every string starts with a 16-bit little-endian
// code-unit count and carries UTF-16LE units, each turned into one to three UTF-8 bytes;
// surrogates are encoded one by one. In narrow mode (source_format 1) a one-byte length is
// followed by bytes that pass through unchanged. string_end marks the last byte of a string and
// run_last the last output beat caused by one input beat. Parsing stops on a string that would
// run past total_bytes or after sixteen strings; bytes past total_bytes are dropped. Each input
// beat is parsed in the cycle it is accepted and its output bytes (up to three) land in a result
// register that drains one byte per cycle while the output is not stalled. A beat that yields
// no byte leaves the register empty; one that yields bytes holds the input until all have left.
// A wide code unit takes two input beats, a narrow byte one. The next input beat is taken in the
// same cycle the last pending output byte leaves. Configuration writes are always ready and take
// effect on the next beat; they never restart parsing. Only reset starts a new block.
module length_prefixed_string_deframer_top
  import lpsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [20:0] cfg_data,
  // input byte channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  // output byte channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] str_id,
  output logic [7:0]  out_byte,
  output logic        string_end,
  output logic        run_last
);

  typedef enum logic [1:0] {PH_LEN_LO, PH_LEN_HI, PH_DATA, PH_DONE} phase_t;

  // configuration registers
  logic                source_format;
  logic [ID_W-1:0]     block_number;
  logic [OFFSET_W-1:0] total_bytes;

  // parse state
  phase_t              phase,          phase_next;
  logic [OFFSET_W-1:0] byte_offset,    byte_offset_next;
  logic [IDX_W-1:0]    string_index,   string_index_next;
  logic [15:0]         units_left,     units_left_next;
  logic [7:0]          held_byte,      held_byte_next;
  logic                high_half_next, high_half_next_next;

  // result register: up to three bytes of one input beat
  logic                busy;
  logic [1:0]          pos;
  logic [1:0]          last_pos;
  logic [7:0]          res_byte [3];
  logic [ID_W-1:0]     res_id;
  logic                res_last_unit;

  // per-beat outputs of the parser
  logic [1:0]          emit_cnt;
  logic [7:0]          emit_byte [3];
  logic                emit_last_unit;

  logic                in_fire;
  logic                out_fire;
  logic                drain_done;

  logic [ID_W-1:0]     cur_id;
  logic [OFFSET_W:0]   offset_inc;
  logic [OFFSET_W:0]   total_ext;
  logic [15:0]         unit;
  logic [15:0]         units_dec;

  assign cfg_ready  = 1'b1;
  assign out_fire   = out_valid && !out_stall;
  assign drain_done = out_fire && (pos == last_pos);
  // take a new beat when the result register is empty or emptying now
  assign in_stall   = busy && !drain_done;
  assign in_fire    = in_valid && !in_stall;

  assign cur_id     = ((block_number - 16'd1) << 4) + {{(ID_W-IDX_W){1'b0}}, string_index};
  assign offset_inc = {1'b0, byte_offset} + {{OFFSET_W{1'b0}}, 1'b1};
  assign total_ext  = {1'b0, total_bytes};
  assign unit       = {data_byte, held_byte};
  assign units_dec  = units_left - 16'd1;

  always_comb begin
    logic [15:0]       len;
    logic [OFFSET_W:0] need;
    logic              start;
    logic              advance;
    logic [IDX_W-1:0]  idx_inc;

    phase_next          = phase;
    byte_offset_next    = byte_offset;
    string_index_next   = string_index;
    units_left_next     = units_left;
    held_byte_next      = held_byte;
    high_half_next_next = high_half_next;
    emit_cnt            = 2'd0;
    emit_byte[0]        = data_byte;
    emit_byte[1]        = 8'h00;
    emit_byte[2]        = 8'h00;
    emit_last_unit      = 1'b0;
    len                 = 16'd0;
    need                = '0;
    start               = 1'b0;
    advance             = 1'b0;
    idx_inc             = string_index + 5'd1;

    if (byte_offset < total_bytes) begin
      byte_offset_next = offset_inc[OFFSET_W-1:0];
      if (phase != PH_DONE) begin
        if (source_format == FMT_NARROW) begin
          if (phase != PH_DATA) begin
            len   = {8'h00, data_byte};
            need  = offset_inc + {{(OFFSET_W-7){1'b0}}, data_byte};
            start = 1'b1;
          end else begin
            emit_cnt        = 2'd1;
            units_left_next = units_dec;
            emit_last_unit  = (units_dec == 16'd0);
          end
        end else begin
          case (phase)
            PH_LEN_LO: begin
              if ({1'b0, byte_offset} + 22'd2 > total_ext) begin
                phase_next = PH_DONE;
              end else begin
                held_byte_next = data_byte;
                phase_next     = PH_LEN_HI;
              end
            end
            PH_LEN_HI: begin
              len   = unit;
              need  = offset_inc + {{(OFFSET_W-16){1'b0}}, unit, 1'b0};
              start = 1'b1;
            end
            default: begin
              if (!high_half_next) begin
                held_byte_next      = data_byte;
                high_half_next_next = 1'b1;
              end else begin
                high_half_next_next = 1'b0;
                if (unit < UTF8_ONE_LIMIT) begin
                  emit_cnt     = 2'd1;
                  emit_byte[0] = unit[7:0];
                end else if (unit < UTF8_TWO_LIMIT) begin
                  emit_cnt     = 2'd2;
                  emit_byte[0] = UTF8_LEAD2 | {3'b000, unit[10:6]};
                  emit_byte[1] = UTF8_CONT | {2'b00, unit[5:0] & UTF8_CONT_MASK};
                end else begin
                  emit_cnt     = 2'd3;
                  emit_byte[0] = UTF8_LEAD3 | {4'h0, unit[15:12]};
                  emit_byte[1] = UTF8_CONT | {2'b00, unit[11:6] & UTF8_CONT_MASK};
                  emit_byte[2] = UTF8_CONT | {2'b00, unit[5:0] & UTF8_CONT_MASK};
                end
                units_left_next = units_dec;
                emit_last_unit  = (units_dec == 16'd0);
              end
            end
          endcase
        end

        if (start) begin
          if (need > total_ext) begin
            phase_next = PH_DONE;
          end else begin
            units_left_next     = len;
            high_half_next_next = 1'b0;
            if (len == 16'd0) begin
              advance = 1'b1;
            end else begin
              phase_next = PH_DATA;
            end
          end
        end
        if (emit_last_unit) begin
          advance = 1'b1;
        end
        // close the string: advance the index, stop once the table is full
        if (advance) begin
          string_index_next   = idx_inc;
          high_half_next_next = 1'b0;
          phase_next = (idx_inc >= IDX_W'(STRINGS_PER_BLOCK)) ? PH_DONE : PH_LEN_LO;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      source_format  <= FMT_WIDE;
      block_number   <= 16'd1;
      total_bytes    <= '0;
      phase          <= PH_LEN_LO;
      byte_offset    <= '0;
      string_index   <= '0;
      units_left     <= '0;
      held_byte      <= '0;
      high_half_next <= 1'b0;
      busy           <= 1'b0;
      pos            <= 2'd0;
      last_pos       <= 2'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SOURCE_FORMAT: source_format <= cfg_data[0];
          REG_BLOCK_NUMBER:  block_number  <= cfg_data[15:0];
          REG_TOTAL_BYTES:   total_bytes   <= cfg_data;
          default: ;
        endcase
      end

      if (in_fire) begin
        phase          <= phase_next;
        byte_offset    <= byte_offset_next;
        string_index   <= string_index_next;
        units_left     <= units_left_next;
        held_byte      <= held_byte_next;
        high_half_next <= high_half_next_next;
        // load the result register, or leave it empty when the beat yields nothing
        busy <= (emit_cnt != 2'd0);
        pos  <= 2'd0;
        if (emit_cnt != 2'd0) begin
          last_pos <= emit_cnt - 2'd1;
        end
      end else if (out_fire) begin
        // step through the held bytes, free the register after the last one
        if (drain_done) begin
          busy <= 1'b0;
        end else begin
          pos <= pos + 2'd1;
        end
      end
    end
  end

  // result payload: load with each productive beat, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire && emit_cnt != 2'd0) begin
      res_byte[0]   <= emit_byte[0];
      res_byte[1]   <= emit_byte[1];
      res_byte[2]   <= emit_byte[2];
      res_id        <= cur_id;
      res_last_unit <= emit_last_unit;
    end
  end

  assign out_valid  = busy;
  assign str_id     = res_id;
  assign out_byte   = res_byte[pos];
  assign run_last   = (pos == last_pos);
  assign string_end = res_last_unit && (pos == last_pos);

`ifndef SYNTH
  a_idle_takes_input: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !in_stall) else $error("input stalled with empty result register");
  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (pos <= last_pos)) else $error("result pointer past last byte");
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && string_end) |-> run_last) else $error("string end not on last beat");
  a_done_sticks: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DONE) |=> (phase == PH_DONE)) else $error("parser left done state");
`endif

endmodule

[tb/sv/lpsd_checker.sv]
`timescale 1ns / 1ps
// Checker for the length-prefixed string deframer: watches the config, input and output
// channels, predicts every output beat and compares. Depends on lpsd_pkg.
module lpsd_checker
  import lpsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [20:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] str_id,
  input  logic [7:0]  out_byte,
  input  logic        string_end,
  input  logic        run_last,
  output int          fail_count,
  output int          pending
);

  typedef enum logic [1:0] {
    PARSE_LEN_LO,
    PARSE_LEN_HI,
    PARSE_DATA,
    PARSE_DONE
  } parse_phase_t;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  data;
    logic        str_end;
    logic        beat_last;
  } out_beat_t;

  // register copies
  logic        fmt;
  logic [15:0] blk;
  logic [20:0] total;

  // parser copy
  parse_phase_t phase;
  int unsigned  offset;
  logic [4:0]   sidx;
  logic [15:0]  units_left;
  logic [7:0]   low_byte;
  logic         high_next;

  out_beat_t expected_beats[$];
  int        mismatches;

  function automatic logic [15:0] current_string_id();
    logic [15:0] base;
    base = blk - 16'd1;
    base = base << 4;
    return base + {11'd0, sidx};
  endfunction

  function automatic void next_string();
    sidx = sidx + 5'd1;
    phase = (sidx >= STRINGS_PER_BLOCK) ? PARSE_DONE : PARSE_LEN_LO;
    high_next = 1'b0;
  endfunction

  // length complete: stop on a string that overruns the data, skip an empty one
  function automatic void open_string(input logic [15:0] len, input int unsigned span);
    if (offset + span > total) begin
      phase = PARSE_DONE;
      return;
    end
    units_left = len;
    high_next = 1'b0;
    if (units_left == 16'd0) next_string();
    else phase = PARSE_DATA;
  endfunction

  function automatic void parse_byte(input logic [7:0] b);
    logic [15:0] unit;
    logic [7:0]  enc [0:2];
    logic [15:0] id;
    logic        last_unit;
    int          n;
    out_beat_t   nb;
    if (offset >= total) return;
    id = current_string_id();
    if (phase == PARSE_DONE) begin
      offset++;
      return;
    end
    if (fmt == FMT_NARROW) begin
      offset++;
      if (phase != PARSE_DATA) begin
        open_string({8'h00, b}, {24'd0, b});
        return;
      end
      enc[0] = b;
      n = 1;
    end else if (phase == PARSE_LEN_LO) begin
      offset++;
      if (offset + 1 > total) begin
        phase = PARSE_DONE;
        return;
      end
      low_byte = b;
      phase = PARSE_LEN_HI;
      return;
    end else if (phase == PARSE_LEN_HI) begin
      unit = {b, low_byte};
      offset++;
      open_string(unit, 2 * {16'd0, unit});
      return;
    end else begin
      offset++;
      if (!high_next) begin
        low_byte = b;
        high_next = 1'b1;
        return;
      end
      high_next = 1'b0;
      unit = {b, low_byte};
      if (unit < UTF8_ONE_LIMIT) begin
        enc[0] = unit[7:0];
        n = 1;
      end else if (unit < UTF8_TWO_LIMIT) begin
        enc[0] = UTF8_LEAD2 | {3'b000, unit[10:6]};
        enc[1] = UTF8_CONT | {2'b00, unit[5:0] & UTF8_CONT_MASK};
        n = 2;
      end else begin
        enc[0] = UTF8_LEAD3 | {4'b0000, unit[15:12]};
        enc[1] = UTF8_CONT | {2'b00, unit[11:6]};
        enc[2] = UTF8_CONT | {2'b00, unit[5:0] & UTF8_CONT_MASK};
        n = 3;
      end
    end
    units_left = units_left - 16'd1;
    last_unit = (units_left == 16'd0);
    for (int k = 0; k < n; k++) begin
      nb.id = id;
      nb.data = enc[k];
      nb.str_end = (k == n - 1) && last_unit;
      nb.beat_last = (k == n - 1);
      expected_beats.insert(expected_beats.size(), nb);
    end
    if (last_unit) next_string();
  endfunction

  always @(posedge clk) begin
    out_beat_t got;
    out_beat_t want;
    if (rst) begin
      fmt = FMT_WIDE;
      blk = 16'd1;
      total = 21'd0;
      phase = PARSE_LEN_LO;
      offset = 0;
      sidx = 5'd0;
      units_left = 16'd0;
      low_byte = 8'd0;
      high_next = 1'b0;
      expected_beats.delete();
      mismatches = 0;
    end else begin
      // compare the output beat first: it stems from an earlier input beat
      if (out_valid && !out_stall) begin
        got = {str_id, out_byte, string_end, run_last};
        if (expected_beats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected output beat: id %h byte %h end %b last %b",
                     got.id, got.data, got.str_end, got.beat_last);
        end else begin
          want = expected_beats.pop_front();
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: expected id %h byte %h end %b last %b,",
                       want.id, want.data, want.str_end, want.beat_last);
              $display("          got id %h byte %h end %b last %b",
                       got.id, got.data, got.str_end, got.beat_last);
            end
          end
        end
      end
      if (in_valid && !in_stall) parse_byte(data_byte);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SOURCE_FORMAT: fmt = cfg_data[0];
          REG_BLOCK_NUMBER:  blk = cfg_data[15:0];
          REG_TOTAL_BYTES:   total = cfg_data;
          default: ;
        endcase
      end
    end
    fail_count <= mismatches;
    pending <= expected_beats.size();
  end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// Top of the deframer testbench: clock, reset, stimulus, receiver stalls and the verdict.
// Depends on lpsd_pkg, lpsd_checker and length_prefixed_string_deframer_top.
module testbench;
  import lpsd_pkg::*;

  localparam logic [1:0]  REG_UNUSED     = 2'd3;   // index past the register list
  localparam logic [20:0] MAX_TOTAL      = 21'h1FFFFF;
  localparam int          SETTLE_CYCLES  = 8;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          RANDOM_STRINGS = 9;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [20:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] str_id;
  logic [7:0]  out_byte;
  logic        string_end;
  logic        run_last;

  int fail_count;
  int pending;

  int   hold_pct;     // chance in a hundred that the sender idles a cycle
  int   stall_pct;    // chance in a hundred that the receiver stalls a cycle
  int   idle_mode;
  int   beat_count;
  int   consumed;     // bytes taken since the data size was opened up
  int   quiet;
  logic cur_fmt;

  always #5 clk = ~clk;

  length_prefixed_string_deframer_top dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .str_id     (str_id),
    .out_byte   (out_byte),
    .string_end (string_end),
    .run_last   (run_last)
  );

  lpsd_checker chk (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .str_id     (str_id),
    .out_byte   (out_byte),
    .string_end (string_end),
    .run_last   (run_last),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Receiver side: stall at random with the current pressure.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog: count cycles in which no beat moves on any channel.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Write one register; leave cfg_valid high so back-to-back writes need no drop.
  task automatic cfg_write(input logic [1:0] idx, input logic [20:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_SOURCE_FORMAT) cur_fmt = value[0];
  endtask

  // Offer one input beat, with random sender gaps ahead of it; hold it until taken.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < hold_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    consumed++;
    beat_count++;
    // rotate the idling pattern every couple dozen beats
    if (beat_count % 24 == 0) begin
      idle_mode = (idle_mode + 1) % 4;
      case (idle_mode)
        0: begin hold_pct = 0;  stall_pct <= 0;  end
        1: begin hold_pct = 67; stall_pct <= 0;  end
        2: begin hold_pct = 0;  stall_pct <= 67; end
        default: begin hold_pct = 27; stall_pct <= 27; end
      endcase
    end
  endtask

  task automatic send_unit(input logic [15:0] u);
    send_byte(u[7:0]);
    send_byte(u[15:8]);
  endtask

  // Wide string: 16-bit little-endian count, then units spread over all encoding widths.
  task automatic wide_string(input int units);
    logic [15:0] u;
    send_unit(16'(units));
    for (int i = 0; i < units; i++) begin
      case ($urandom_range(3))
        0: u = 16'($urandom_range(16'h007F));
        1: u = 16'($urandom_range(16'h07FF, 16'h0080));
        2: u = 16'($urandom_range(16'hFFFF, 16'h0800));
        default: u = 16'($urandom_range(16'hDFFF, 16'hD800));   // lone surrogates
      endcase
      send_unit(u);
    end
  endtask

  task automatic narrow_string(input int len);
    send_byte(8'(len));
    for (int i = 0; i < len; i++) send_byte(8'($urandom_range(255)));
  endtask

  // Go idle: drop valid, wait for every predicted beat, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int r;
    int len;
    rst <= 1'b1;
    in_valid <= 1'b0;
    data_byte <= 8'd0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_SOURCE_FORMAT;
    cfg_data <= 21'd0;
    stall_pct <= 0;
    hold_pct = 0;
    idle_mode = 0;
    beat_count = 0;
    consumed = 0;
    cur_fmt = FMT_WIDE;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Zero data size: every byte is dropped and the parser does not move.
    // Also poke the unused index, which must change nothing.
    cfg_write(REG_TOTAL_BYTES, 21'd0);
    cfg_write(REG_SOURCE_FORMAT, 21'(FMT_NARROW));
    cfg_write(REG_UNUSED, 21'($urandom));
    cfg_valid <= 1'b0;
    repeat (3) send_byte(8'($urandom_range(255)));
    drain();

    // Open the data size fully; block 0 makes the ids wrap to the top of the range.
    cfg_write(REG_TOTAL_BYTES, MAX_TOTAL);
    cfg_write(REG_BLOCK_NUMBER, 21'd0);
    cfg_write(REG_SOURCE_FORMAT, 21'(FMT_WIDE));
    cfg_valid <= 1'b0;
    consumed = 0;

    // Empty wide string: advances the index and emits nothing.
    send_unit(16'h0000);
    // Unit extremes and every encoding-width boundary.
    send_unit(16'd6);
    send_unit(16'h0000);
    send_unit(16'h007F);
    send_unit(16'h0080);
    send_unit(16'h07FF);
    send_unit(16'h0800);
    send_unit(16'hFFFF);
    // Lone high surrogate, then a unit cut in half by a switch to narrow mode:
    // the narrow byte finishes the string on its own.
    send_unit(16'd2);
    send_unit(16'hD800);
    send_byte(8'h34);
    drain();
    cfg_write(REG_BLOCK_NUMBER, 21'd65535);
    cfg_write(REG_SOURCE_FORMAT, 21'(FMT_NARROW));
    cfg_valid <= 1'b0;
    send_byte(8'hAB);
    // Narrow byte extremes, then an empty narrow string.
    send_byte(8'd3);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'd0);
    // Switch back to narrow while the wide length waits for its high byte:
    // that byte is taken as a narrow length.
    drain();
    cfg_write(REG_SOURCE_FORMAT, 21'(FMT_WIDE));
    cfg_valid <= 1'b0;
    send_byte(8'd2);
    drain();
    cfg_write(REG_SOURCE_FORMAT, 21'(FMT_NARROW));
    cfg_valid <= 1'b0;
    send_byte(8'd2);
    send_byte(8'h55);
    send_byte(8'hAA);

    // Random strings: six slots are used already, nine more leave one slot for the closing case.
    for (int s = 0; s < RANDOM_STRINGS; s++) begin
      if ($urandom_range(1)) begin
        drain();
        cfg_write(REG_SOURCE_FORMAT, 21'($urandom_range(1)));
        if ($urandom_range(1)) begin
          case ($urandom_range(3))
            0: cfg_write(REG_BLOCK_NUMBER, 21'd0);
            1: cfg_write(REG_BLOCK_NUMBER, 21'd1);
            2: cfg_write(REG_BLOCK_NUMBER, 21'd65535);
            default: cfg_write(REG_BLOCK_NUMBER, 21'($urandom_range(65535)));
          endcase
        end
        cfg_valid <= 1'b0;
      end
      if ($urandom_range(7) == 0) begin
        if (cur_fmt == FMT_WIDE) send_unit(16'h0000);
        else send_byte(8'd0);
      end else if (cur_fmt == FMT_WIDE) begin
        wide_string($urandom_range(16, 3));
      end else begin
        narrow_string($urandom_range(32, 6));
      end
    end

    // Close the block one of four ways; only one fits, since parsing never restarts.
    case ($urandom_range(3))
      0: begin
        // table full: the sixteenth string ends parsing, later bytes are swallowed
        if (cur_fmt == FMT_WIDE) wide_string(3);
        else narrow_string(5);
        repeat (6) send_byte(8'($urandom_range(255)));
        drain();
        cfg_write(REG_TOTAL_BYTES, 21'(consumed));
        cfg_valid <= 1'b0;
      end
      1: begin
        // narrow length that overruns the data
        drain();
        r = $urandom_range(20);
        cfg_write(REG_SOURCE_FORMAT, 21'(FMT_NARROW));
        cfg_write(REG_TOTAL_BYTES, 21'(consumed + 1 + r));
        cfg_valid <= 1'b0;
        send_byte(8'(r + 1 + $urandom_range(100)));
      end
      2: begin
        // wide count one byte too long for the data
        drain();
        len = $urandom_range(60, 1);
        cfg_write(REG_SOURCE_FORMAT, 21'(FMT_WIDE));
        cfg_write(REG_TOTAL_BYTES, 21'(consumed + 2 * len + 1));
        cfg_valid <= 1'b0;
        send_unit(16'(len));
      end
      default: begin
        // wide length low byte with a single byte of data left
        drain();
        cfg_write(REG_SOURCE_FORMAT, 21'(FMT_WIDE));
        cfg_write(REG_TOTAL_BYTES, 21'(consumed + 1));
        cfg_valid <= 1'b0;
        send_byte(8'($urandom_range(255)));
      end
    endcase
    // trailing noise: consumed or dropped, never emitted
    repeat (6) send_byte(8'($urandom_range(255)));

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
